// ===== src/lmls_pkg.sv =====
// Shared types and constants for the LCD mode and line sequencer.
`timescale 1ns / 1ps
package lmls_pkg;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lcd_mode_t;

	// result word, first member is the top bits
	typedef struct packed {
		logic      frame_done;
		logic      hblank_entered;
		logic      stat_irq;
		logic      vblank_irq;
		logic      coincidence;
		lcd_mode_t lcd_mode;
		logic [7:0] line_number;
	} lcd_result_t;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;
	localparam int RESULT_W    = $bits(lcd_result_t);

	localparam logic [7:0] LINE_VBLANK_FIRST = 8'd144;
	localparam logic [7:0] LINE_VBLANK_SHORT = 8'd153;

	localparam logic signed [11:0] VBL_ENTRY_DMG  = 12'sd28;
	localparam logic signed [11:0] VBL_ENTRY_CGB  = 12'sd22;
	localparam logic signed [11:0] VBL_FIRST_DMG  = 12'sd428;
	localparam logic signed [11:0] VBL_FIRST_CGB  = 12'sd434;
	localparam logic signed [11:0] VBL_SHORT_LINE = 12'sd24;
	localparam logic signed [11:0] VBL_WRAP_LINE  = 12'sd450;

	localparam logic [8:0] STAT_LYC_DELAY = 9'd36;

	localparam logic signed [9:0]  OFF_LINE_SPAN = 10'sd456;
	localparam logic signed [9:0]  OFF_OAM_START = 10'sd353;
	localparam logic signed [17:0] FRAME_RESET   = 18'sd70224;

endpackage

// ===== src/lcd_mode_line_sequencer.sv =====
// LCD mode and line sequencer: mode timing, line count and interrupt pulses.
//
// Usage:
//  - s_* carries one tick per request: elapsed dot cycles, LCD enable, the
//    four STAT enables and the line compare value.
//  - m_* returns one result per tick: line, mode, coincidence flag and the
//    vblank, STAT, hblank-entered and frame pulses.
//  - cfg_* writes the color-model select; it is always ready. The user must
//    write it only while no tick is in flight; the block does not enforce this.
// A tick taken at a clock edge shows on m_* in the cycle after it.
// Throughput is one tick per clock while m_tready is high; the whole
// mode/line update is one pass of logic from the state registers and the
// request into the state and result registers.
// The result register frees in the cycle it is taken, so s_tready stays high
// while m_tready is high. When the receiver stalls with a result held,
// s_tready drops until that result is taken; state then holds.
// Reset clears mode, line and all counters, sets the frame countdown to a
// full frame and empties the result register.
`timescale 1ns / 1ps
module lcd_mode_line_sequencer
	import lmls_pkg::*;
#(
	parameter int OAM_CYCLES         = 80,
	parameter int TRANSFER_CYCLES    = 172,
	parameter int HBLANK_SPAN_CYCLES = 376,
	parameter int VBLANK_LINE_CYCLES = 456,
	parameter int FRAME_CYCLES       = 70224
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [4:0] dot_cycles, [5] lcd_enable, [9:6] stat_enables, [17:10] line_compare
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [7:0] line_number, [9:8] lcd_mode, [10] coincidence, [11] vblank_irq,
	// [12] stat_irq, [13] hblank_entered, [14] frame_done
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	localparam logic signed [11:0] OAM_ADD  = 12'(OAM_CYCLES);
	localparam logic signed [11:0] XFER_ADD = 12'(TRANSFER_CYCLES);
	localparam logic signed [11:0] HB_ADD   = 12'(HBLANK_SPAN_CYCLES - TRANSFER_CYCLES);
	localparam logic signed [11:0] VBL_ADD  = 12'(VBLANK_LINE_CYCLES);
	localparam logic signed [17:0] FRAME_ADD = 18'(FRAME_CYCLES);
	localparam int HB_DLY_RAW = HBLANK_SPAN_CYCLES - 58;
	localparam logic [8:0] HB_STAT_DELAY =
		9'((HB_DLY_RAW < 0) ? 0 : ((HB_DLY_RAW > 511) ? 511 : HB_DLY_RAW));

	// state
	logic signed [11:0] mode_cnt_q;
	lcd_mode_t          mode_q;
	logic [7:0]         line_q;
	logic               vbl_pend_q;
	logic [8:0]         stat_dly_q;
	logic signed [9:0]  off_cnt_q;
	logic signed [17:0] frame_cnt_q;
	logic               color_q;
	logic               out_valid_q;
	lcd_result_t        result_q;

	// request fields
	logic [4:0] dots;
	logic       lcd_on;
	logic       en_hb, en_vb, en_oam, en_co;
	logic [7:0] lyc;
	logic       accept;

	// next-state terms
	logic signed [11:0] mode_cnt_dec, mode_add, mode_cnt_d;
	logic signed [17:0] frame_dec, frame_d;
	logic signed [9:0]  off_dec, off_d;
	logic [7:0]         line_inc, line_d;
	logic               expired, frame_expired;
	lcd_mode_t          mode_d;
	logic               vbl_pend_d;

	// output terms
	logic       vb_irq, st_irq, hb_pulse, frame_pulse;
	logic       load_lyc_dly, load_hb_dly;
	logic [8:0] stat_dly_mid, stat_dly_d;
	logic       dly_fire;

	assign dots   = s_tdata[4:0];
	assign lcd_on = s_tdata[5];
	assign en_hb  = s_tdata[6];
	assign en_vb  = s_tdata[7];
	assign en_oam = s_tdata[8];
	assign en_co  = s_tdata[9];
	assign lyc    = s_tdata[17:10];

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign mode_cnt_dec  = mode_cnt_q - $signed({7'd0, dots});
	assign expired       = mode_cnt_dec[11] || (mode_cnt_dec == 12'sd0);
	assign frame_dec     = frame_cnt_q - $signed({13'd0, dots});
	assign frame_expired = frame_dec[17] || (frame_dec == 18'sd0);
	assign off_dec       = off_cnt_q - $signed({5'd0, dots});
	assign line_inc      = line_q + 8'd1;

	// next state
	always_comb begin
		mode_d     = mode_q;
		line_d     = line_q;
		vbl_pend_d = vbl_pend_q;
		mode_add   = 12'sd0;
		mode_cnt_d = mode_cnt_q;
		frame_d    = frame_dec;
		off_d      = off_cnt_q;
		if (lcd_on) begin
			if (expired) begin
				unique case (mode_q)
					MODE_HBLANK: begin
						line_d = line_inc;
						if (line_inc >= LINE_VBLANK_FIRST) begin
							mode_d     = MODE_VBLANK;
							frame_d    = frame_dec + FRAME_ADD;
							vbl_pend_d = 1'b1;
							mode_add   = color_q ? VBL_ENTRY_CGB : VBL_ENTRY_DMG;
						end else begin
							mode_d   = MODE_OAM;
							mode_add = OAM_ADD;
						end
					end
					MODE_VBLANK: begin
						if (vbl_pend_q) begin
							mode_add   = color_q ? VBL_FIRST_CGB : VBL_FIRST_DMG;
							vbl_pend_d = 1'b0;
						end else if (line_q == 8'd0) begin
							mode_d   = MODE_OAM;
							mode_add = OAM_ADD;
						end else if (line_q < LINE_VBLANK_SHORT) begin
							line_d   = line_inc;
							mode_add = (line_inc >= LINE_VBLANK_SHORT) ? VBL_SHORT_LINE : VBL_ADD;
						end else begin
							line_d   = 8'd0;
							mode_add = VBL_WRAP_LINE;
						end
					end
					MODE_OAM: begin
						mode_d   = MODE_XFER;
						mode_add = XFER_ADD;
					end
					MODE_XFER: begin
						mode_d   = MODE_HBLANK;
						mode_add = HB_ADD;
					end
				endcase
			end
			mode_cnt_d = mode_cnt_dec + mode_add;
		end else begin
			off_d = (off_dec[9] || off_dec == 10'sd0) ? off_dec + OFF_LINE_SPAN : off_dec;
			mode_d = (off_d >= OFF_OAM_START) ? MODE_OAM : MODE_HBLANK;
			if (frame_expired) begin
				frame_d = frame_dec + FRAME_ADD;
			end
		end
	end

	// pulses and delayed STAT request
	always_comb begin
		vb_irq       = 1'b0;
		st_irq       = 1'b0;
		hb_pulse     = 1'b0;
		frame_pulse  = 1'b0;
		load_lyc_dly = 1'b0;
		load_hb_dly  = 1'b0;
		if (lcd_on) begin
			if (expired) begin
				unique case (mode_q)
					MODE_HBLANK: begin
						if (line_inc >= LINE_VBLANK_FIRST) begin
							frame_pulse = 1'b1;
						end else begin
							load_lyc_dly = en_co && (line_inc == lyc);
							st_irq       = !en_co && en_oam;
						end
					end
					MODE_VBLANK: begin
						if (vbl_pend_q) begin
							vb_irq = 1'b1;
							st_irq = en_vb || (en_co && line_q == lyc);
						end else if (line_q != 8'd0) begin
							load_hb_dly = color_q && (line_d >= LINE_VBLANK_SHORT) &&
								!en_co && en_hb;
							st_irq = en_co && (line_d == lyc);
						end
					end
					MODE_OAM: begin
					end
					MODE_XFER: begin
						st_irq   = en_hb;
						hb_pulse = 1'b1;
					end
				endcase
			end
		end else begin
			frame_pulse = frame_expired;
		end

		priority if (load_lyc_dly) begin
			stat_dly_mid = STAT_LYC_DELAY;
		end else if (load_hb_dly) begin
			stat_dly_mid = HB_STAT_DELAY;
		end else begin
			stat_dly_mid = stat_dly_q;
		end

		// a zero count is idle; otherwise it fires once it runs out
		dly_fire   = (stat_dly_mid != 9'd0) && (stat_dly_mid <= {4'd0, dots});
		stat_dly_d = dly_fire ? 9'd0 :
			((stat_dly_mid != 9'd0) ? stat_dly_mid - {4'd0, dots} : 9'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cnt_q  <= '0;
			mode_q      <= MODE_HBLANK;
			line_q      <= '0;
			vbl_pend_q  <= 1'b0;
			stat_dly_q  <= '0;
			off_cnt_q   <= '0;
			frame_cnt_q <= FRAME_RESET;
			color_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
			if (accept) begin
				mode_cnt_q  <= mode_cnt_d;
				mode_q      <= mode_d;
				line_q      <= line_d;
				vbl_pend_q  <= vbl_pend_d;
				stat_dly_q  <= stat_dly_d;
				off_cnt_q   <= off_d;
				frame_cnt_q <= frame_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.line_number    <= line_d;
			result_q.lcd_mode       <= mode_d;
			result_q.coincidence    <= (line_d == lyc);
			result_q.vblank_irq     <= vb_irq;
			result_q.stat_irq       <= st_irq || dly_fire;
			result_q.hblank_entered <= hb_pulse;
			result_q.frame_done     <= frame_pulse;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result_q};

endmodule

// ===== src/lmls_checker.sv =====
// Port-level checks for the LCD mode and line sequencer, bound to the top level.
`timescale 1ns / 1ps
module lmls_checker
	import lmls_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	lcd_result_t res;
	assign res = lcd_result_t'(m_tdata[RESULT_W-1:0]);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// input only backs up behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a held result");

	// one mode transition per tick: at most one of these pulses
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({res.vblank_irq, res.hblank_entered, res.frame_done}))
		else $error("more than one transition pulse in one result");

	a_hb_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.hblank_entered |-> res.lcd_mode == MODE_HBLANK)
		else $error("hblank pulse outside hblank");

	a_vb_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.vblank_irq |-> res.lcd_mode == MODE_VBLANK)
		else $error("vblank interrupt outside vblank");

endmodule

bind lcd_mode_line_sequencer lmls_checker u_lmls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
